// ===== rtl/rse_pkg.sv =====
// Shared types and constants for the ring stack expression ALU.
// Used by rse_alu, rse_cell and ring_stack_expression_alu; no dependencies.
package rse_pkg;

  // Data path and stack geometry
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned OP_W        = 5;
  localparam int unsigned STACK_DEPTH = 16;

  localparam logic [DATA_W-1:0] SIGN_MASK = 16'h8000;

  typedef logic [DATA_W-1:0] data_t;

  // Operation codes carried by a transaction
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 5'd0,
    OP_SIGN = 5'd1,
    OP_NOT  = 5'd2,
    OP_ADD  = 5'd3,
    OP_SUB  = 5'd4,
    OP_MUL  = 5'd5,
    OP_EQ   = 5'd6,
    OP_NEQ  = 5'd7,
    OP_LT   = 5'd8,
    OP_LE   = 5'd9,
    OP_ULT  = 5'd10,
    OP_ULE  = 5'd11,
    OP_AND  = 5'd12,
    OP_OR   = 5'd13,
    OP_XOR  = 5'd14,
    OP_SHR  = 5'd15,
    OP_SAR  = 5'd16,
    OP_SHL  = 5'd17
  } opcode_e;

  // What a stack cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_FROM_PREV = 2'd1,
    CELL_FROM_NEXT = 2'd2,
    CELL_LOAD      = 2'd3
  } cell_mode_e;

endpackage

// ===== rtl/rse_alu.sv =====
// Combinational operation unit: computes the new top of stack from the
// two topmost cells and the pushed value. Depends on rse_pkg.
module rse_alu (
  input  rse_pkg::opcode_e op_i,
  input  rse_pkg::data_t   rhs_i,
  input  rse_pkg::data_t   lhs_i,
  input  rse_pkg::data_t   push_i,
  output rse_pkg::data_t   top_o
);
  import rse_pkg::*;

  logic  big_shift;
  data_t prod;

  // any amount of 16 or more clears or sign-fills
  assign big_shift = |rhs_i[DATA_W-1:4];
  assign prod      = lhs_i * rhs_i;

  always_comb begin
    case (op_i)
      OP_PUSH: top_o = push_i;
      OP_SIGN: top_o = rhs_i ^ SIGN_MASK;
      OP_NOT:  top_o = ~rhs_i;
      OP_ADD:  top_o = lhs_i + rhs_i;
      OP_SUB:  top_o = lhs_i - rhs_i;
      OP_MUL:  top_o = prod;
      OP_EQ:   top_o = {{(DATA_W-1){1'b0}}, lhs_i == rhs_i};
      OP_NEQ:  top_o = {{(DATA_W-1){1'b0}}, lhs_i != rhs_i};
      OP_LT:   top_o = {{(DATA_W-1){1'b0}}, $signed(lhs_i) < $signed(rhs_i)};
      OP_LE:   top_o = {{(DATA_W-1){1'b0}}, $signed(lhs_i) <= $signed(rhs_i)};
      OP_ULT:  top_o = {{(DATA_W-1){1'b0}}, lhs_i < rhs_i};
      OP_ULE:  top_o = {{(DATA_W-1){1'b0}}, lhs_i <= rhs_i};
      OP_AND:  top_o = lhs_i & rhs_i;
      OP_OR:   top_o = lhs_i | rhs_i;
      OP_XOR:  top_o = lhs_i ^ rhs_i;
      OP_SHR:  top_o = big_shift ? '0 : (lhs_i >> rhs_i[3:0]);
      OP_SAR:  top_o = big_shift ? {DATA_W{lhs_i[DATA_W-1]}}
                                 : data_t'($signed(lhs_i) >>> rhs_i[3:0]);
      OP_SHL:  top_o = big_shift ? '0 : (lhs_i << rhs_i[3:0]);
      default: top_o = rhs_i;  // unused codes leave the top as is
    endcase
  end

endmodule

// ===== rtl/rse_cell.sv =====
// One stack cell: holds a single entry and takes its neighbor's entry,
// a loaded value, or keeps its own. Depends on rse_pkg.
module rse_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rse_pkg::cell_mode_e  mode_i,
  input  rse_pkg::data_t       prev_i,
  input  rse_pkg::data_t       next_i,
  input  rse_pkg::data_t       load_i,
  output rse_pkg::data_t       val_o
);
  import rse_pkg::*;

  data_t val_d, val_q;

  // next entry select
  always_comb begin
    case (mode_i)
      CELL_FROM_PREV: val_d = prev_i;
      CELL_FROM_NEXT: val_d = next_i;
      CELL_LOAD:      val_d = load_i;
      default:        val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

// ===== rtl/ring_stack_expression_alu.sv =====
// Top level of the ring stack expression ALU: a ring of stack cells with
// the top always in cell 0, an operation unit and an output register.
// Depends on rse_pkg, rse_alu and rse_cell.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o | opcode_i, push_value_i
//  out     | output    | out_valid_o/ out_stall_i| top_value_o
//
// One transaction per cycle unless stalled: an accepted operation updates
// the cell ring and loads the output register on the same edge, its
// result is offered on the next cycle. Push rotates the ring down, binary
// operations rotate it up, both in a single shift of the cell chain.
// Reset clears every cell to zero and empties the output register.
// in_stall_o is raised only while a result waits and out_stall_i is high.
module ring_stack_expression_alu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rse_pkg::OP_W-1:0]           opcode_i,
  input  logic signed [rse_pkg::DATA_W-1:0]  push_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [rse_pkg::DATA_W-1:0]  top_value_o
);
  import rse_pkg::*;

  opcode_e    op;
  logic       in_acc;
  logic       is_push;
  logic       is_binary;
  logic       is_unary;
  data_t      new_top;
  data_t      cell_val [STACK_DEPTH];
  cell_mode_e cell_mode[STACK_DEPTH];

  logic  out_valid_d, out_valid_q;
  data_t top_d, top_q;

  assign op        = opcode_e'(opcode_i);
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc    = in_valid_i & ~in_stall_o;

  // operation class decode
  assign is_push   = (op == OP_PUSH);
  assign is_unary  = (op == OP_SIGN) || (op == OP_NOT);
  assign is_binary = (opcode_i >= OP_ADD) && (opcode_i <= OP_SHL);

  rse_alu u_alu (
    .op_i   (op),
    .rhs_i  (cell_val[0]),
    .lhs_i  (cell_val[1]),
    .push_i (data_t'(push_value_i)),
    .top_o  (new_top)
  );

  // per-cell shift control: cell 0 loads the new top, the rest rotate on push or binary ops
  always_comb begin
    for (int k = 0; k < STACK_DEPTH; k++) begin
      cell_mode[k] = CELL_HOLD;
      if (in_acc) begin
        if (k == 0) begin
          if (is_push || is_unary || is_binary) cell_mode[k] = CELL_LOAD;
        end else if (is_push) begin
          cell_mode[k] = CELL_FROM_PREV;
        end else if (is_binary) begin
          cell_mode[k] = CELL_FROM_NEXT;
        end
      end
    end
  end

  // ring of cells, neighbors wrap around
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    rse_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .mode_i (cell_mode[k]),
      .prev_i (cell_val[(k + STACK_DEPTH - 1) % STACK_DEPTH]),
      .next_i (cell_val[(k + 1) % STACK_DEPTH]),
      .load_i (new_top),
      .val_o  (cell_val[k])
    );
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    top_d       = top_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      top_d       = new_top;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = $signed(top_q);

`ifndef SYNTHESIS
  // a pushed value becomes both the offered result and the top cell
  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_push) |=> (top_q == $past(push_value_i)) && (cell_val[0] == top_q))
    else $error("push did not land on top of stack");

  // a pop rotates the old rhs into the last cell of the ring
  a_pop_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_binary) |=> cell_val[STACK_DEPTH-1] == $past(cell_val[0]))
    else $error("ring did not wrap on pop");

  // a result appears only after an accepted transaction
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc))
    else $error("result without transaction");

  // the offered result always mirrors the top cell
  a_out_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> top_q == cell_val[0])
    else $error("result differs from top of stack");
`endif

endmodule

// ===== tb/sv/tb_ring_stack_expression_alu.sv =====
// Self-checking testbench for ring_stack_expression_alu: a directed table, then random
// transactions, each checked against a predictor of the 16-entry stack ring.
// Depends on rse_pkg and the ring_stack_expression_alu RTL.
`timescale 1ns / 100ps

module tb_ring_stack_expression_alu;
  import rse_pkg::*;

  // Opcodes outside the defined set: the block leaves the stack alone
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 5'd18;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 5'd31;

  localparam int RANDOM_ITEMS   = 1450;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PTR_W          = $clog2(STACK_DEPTH);

  // One directed transaction; top is only used when known is set
  typedef struct packed {
    logic [OP_W-1:0] op;
    data_t           value;
    logic            known;
    data_t           top;
  } calc_row_t;

  localparam int DIRECTED_ROWS = 26;
  localparam calc_row_t DIRECTED [DIRECTED_ROWS] = '{
    // pop at reset wraps past the bottom; push value ignored
    '{OP_ADD,          16'h1234, 1'b1, 16'h0000},
    '{OP_SIGN,         16'hFFFF, 1'b1, 16'h8000},
    '{OP_NOT,          16'h0000, 1'b1, 16'h7FFF},
    '{OP_PUSH,         16'h8000, 1'b1, 16'h8000},
    '{OP_PUSH,         16'h7FFF, 1'b1, 16'h7FFF},
    '{OP_LT,           16'h5A5A, 1'b0, 16'h0000},
    '{OP_PUSH,         16'hFFFF, 1'b1, 16'hFFFF},
    '{OP_ULT,          16'h0000, 1'b0, 16'h0000},
    // shift amounts of 16 and more, then a left shift by 3
    '{OP_PUSH,         16'h0010, 1'b1, 16'h0010},
    '{OP_SAR,          16'h0000, 1'b0, 16'h0000},
    '{OP_PUSH,         16'hFFFF, 1'b1, 16'hFFFF},
    '{OP_SHR,          16'h0000, 1'b0, 16'h0000},
    '{OP_PUSH,         16'h0003, 1'b1, 16'h0003},
    '{OP_SHL,          16'h0000, 1'b0, 16'h0000},
    '{OP_PUSH,         16'h7FFF, 1'b1, 16'h7FFF},
    '{OP_MUL,          16'h0000, 1'b0, 16'h0000},
    '{OP_SUB,          16'hA5A5, 1'b0, 16'h0000},
    '{OP_EQ,           16'h0000, 1'b0, 16'h0000},
    '{OP_NEQ,          16'h0000, 1'b0, 16'h0000},
    '{OP_LE,           16'h0000, 1'b0, 16'h0000},
    '{OP_ULE,          16'h0000, 1'b0, 16'h0000},
    '{OP_AND,          16'h0000, 1'b0, 16'h0000},
    '{OP_OR,           16'h0000, 1'b0, 16'h0000},
    '{OP_XOR,          16'h0000, 1'b0, 16'h0000},
    '{OP_UNUSED_FIRST, 16'hFFFF, 1'b0, 16'h0000},
    '{OP_UNUSED_LAST,  16'h0000, 1'b0, 16'h0000}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [OP_W-1:0]        opcode_i;
  logic signed [DATA_W-1:0] push_value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [DATA_W-1:0] top_value_o;

  // Predictor state
  data_t           calc_ring [STACK_DEPTH];
  logic [PTR_W-1:0] calc_ptr;

  data_t expected_tops [$];
  int    fail_count;
  bit    calm_stretch;
  int    quiet_cycles;

  ring_stack_expression_alu u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .top_value_o  (top_value_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Applies one operation to the predicted ring and returns the new top
  function automatic data_t next_top(input logic [OP_W-1:0] op, input data_t value);
    data_t lhs;
    data_t rhs;
    data_t res;
    case (op)
      OP_PUSH: begin
        calc_ptr = calc_ptr - 1'b1;
        calc_ring[calc_ptr] = value;
      end
      OP_SIGN: calc_ring[calc_ptr] = calc_ring[calc_ptr] ^ SIGN_MASK;
      OP_NOT:  calc_ring[calc_ptr] = ~calc_ring[calc_ptr];
      OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NEQ, OP_LT, OP_LE, OP_ULT, OP_ULE,
      OP_AND, OP_OR, OP_XOR, OP_SHR, OP_SAR, OP_SHL: begin
        // rhs is the top, lhs the entry above it; result lands on lhs
        rhs = calc_ring[calc_ptr];
        calc_ptr = calc_ptr + 1'b1;
        lhs = calc_ring[calc_ptr];
        case (op)
          OP_ADD: res = lhs + rhs;
          OP_SUB: res = lhs - rhs;
          OP_MUL: res = lhs * rhs;
          OP_EQ:  res = data_t'(lhs == rhs);
          OP_NEQ: res = data_t'(lhs != rhs);
          OP_LT:  res = data_t'($signed(lhs) < $signed(rhs));
          OP_LE:  res = data_t'($signed(lhs) <= $signed(rhs));
          OP_ULT: res = data_t'(lhs < rhs);
          OP_ULE: res = data_t'(lhs <= rhs);
          OP_AND: res = lhs & rhs;
          OP_OR:  res = lhs | rhs;
          OP_XOR: res = lhs ^ rhs;
          OP_SHR: res = (rhs >= DATA_W) ? '0 : lhs >> rhs[PTR_W-1:0];
          OP_SAR: res = (rhs >= DATA_W) ? {DATA_W{lhs[DATA_W-1]}}
                                        : data_t'($signed(lhs) >>> rhs[PTR_W-1:0]);
          default: res = (rhs >= DATA_W) ? '0 : lhs << rhs[PTR_W-1:0];
        endcase
        calc_ring[calc_ptr] = res;
      end
      default: ;
    endcase
    return calc_ring[calc_ptr];
  endfunction

  // Drives one transaction, waits for it to be taken, queues its top
  task automatic send_op(input logic [OP_W-1:0] op, input data_t value,
                         input logic known, input data_t top);
    data_t predicted;
    while (!calm_stretch && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    push_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    predicted = next_top(op, value);
    expected_tops.push_back(known ? top : predicted);
    @(negedge clk_i);
  endtask

  // Hold the sender until every queued top has come back
  task automatic drain_results();
    if (expected_tops.size() != 0) begin
      in_valid_i <= 1'b0;
      while (expected_tops.size() != 0) @(negedge clk_i);
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni || calm_stretch) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 36);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tops.size() == 0) begin
        report_mismatch($sformatf("unexpected top 0x%04h", top_value_o));
      end else if (data_t'(top_value_o) !== expected_tops[0]) begin
        report_mismatch($sformatf("top 0x%04h, expected 0x%04h",
                                  top_value_o, expected_tops[0]));
        void'(expected_tops.pop_front());
      end else begin
        void'(expected_tops.pop_front());
      end
    end
  end

  // Watchdog: cycles in which neither channel moves a transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ring_stack_expression_alu regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          pick;
    logic [OP_W-1:0] op;
    data_t       value;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = '0;
    push_value_i = '0;
    calm_stretch = 1'b0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      calc_ring[i] = '0;
    end
    calc_ptr = PTR_W'(STACK_DEPTH - 1);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (DIRECTED[i]) begin
      send_op(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].known, DIRECTED[i].top);
    end
    drain_results();

    // Random transactions: pushes, unary and binary operations, some unused codes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_stretch = (n >= 500 && n < 700);
      if (n == 1000) begin
        drain_results();
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        op = OP_PUSH;
      end else if (pick < 42) begin
        op = $urandom_range(1) ? OP_SIGN : OP_NOT;
      end else if (pick < 95) begin
        op = OP_W'($urandom_range(OP_ADD, OP_SHL));
      end else begin
        op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end
      case ($urandom_range(3))
        0: value = data_t'($urandom_range(0, 20));
        1: begin
          case ($urandom_range(4))
            0: value = 16'h0000;
            1: value = 16'h7FFF;
            2: value = 16'h8000;
            3: value = 16'hFFFF;
            default: value = 16'h0001;
          endcase
        end
        default: value = data_t'($urandom);
      endcase
      send_op(op, value, 1'b0, '0);
    end
    calm_stretch = 1'b0;
    in_valid_i <= 1'b0;

    // Let the pipeline empty, then watch for stray results
    while (expected_tops.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ring_stack_expression_alu regression: pass");
    end else begin
      $display("ring_stack_expression_alu regression: fail");
    end
    $finish;
  end

endmodule
